// ===== sv/lfu_pkg.sv =====
// Package for the LFU cache table: shared widths, request codes, the
// stored row layout and the controller/datapath command and status structs.
// No dependencies.
`default_nettype none

package lfu_pkg;

  localparam int KEY_W   = 32;
  localparam int VAL_W   = 32;
  localparam int CNT_W   = 32;
  localparam int STAMP_W = 64;
  localparam int CAP_W   = 5;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;
  localparam logic [CNT_W-1:0] COUNT_MAX = '1;
  localparam logic [CNT_W-1:0] COUNT_ONE = 32'd1;

  // Request codes
  localparam logic REQ_GET = 1'b0;
  localparam logic REQ_PUT = 1'b1;

  // One stored cache row
  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic [VAL_W-1:0]   value;
    logic [CNT_W-1:0]   count;
    logic [STAMP_W-1:0] stamp;
  } row_t;

  // Controller to datapath
  typedef struct packed {
    logic load;    // latch the request, restart the scan
    logic scan;    // step the table scan
    logic commit;  // write back and load the result register
  } ctl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic scan_last;  // last slot is being compared this cycle
  } ctl_sts_t;

endpackage

`default_nettype wire

// ===== sv/lfu_ctrl.sv =====
// Controller for the LFU cache table: sequences accept, scan and commit,
// and owns the input ready and result valid flags.
// Depends on lfu_pkg.
`default_nettype none

module lfu_ctrl
  import lfu_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  ctl_sts_t sts,
  output ctl_cmd_t cmd
);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SCAN   = 3'b010,
    ST_COMMIT = 3'b100
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_free;

  // Result register is free when empty or being drained this cycle
  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == ST_IDLE);

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_last) begin
          state_next = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        if (out_free) begin
          cmd.commit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // State and result valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.commit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// ===== sv/lfu_datapath.sv =====
// Datapath for the LFU cache table: row memory, valid bits, access clock,
// scan trackers for match, victim and free slot, and the result register.
// Depends on lfu_pkg; driven by lfu_ctrl.
`default_nettype none

module lfu_datapath
  import lfu_pkg::*;
#(
  parameter int ENTRIES = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  ctl_cmd_t                 cmd,
  output ctl_sts_t                 sts,
  input  logic                     cfg_wr,
  input  logic [CAP_W-1:0]         cfg_data,
  input  logic                     req_type,
  input  logic signed [KEY_W-1:0]  key,
  input  logic signed [VAL_W-1:0]  write_value,
  output logic                     hit,
  output logic signed [VAL_W-1:0]  read_value,
  output logic                     evicted,
  output logic signed [KEY_W-1:0]  evicted_key
);

  localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int SCAN_W = $clog2(ENTRIES + 1);
  localparam int OCC_W  = $clog2(ENTRIES + 1);
  localparam int CMP_W  = (OCC_W > CAP_W) ? OCC_W : CAP_W;

  // Storage
  row_t                mem [ENTRIES];
  logic [ENTRIES-1:0]  valid;
  logic [STAMP_W-1:0]  access_clock;
  logic [CAP_W-1:0]    capacity;

  // Latched request
  logic                req_put;
  logic [KEY_W-1:0]    req_key;
  logic [VAL_W-1:0]    req_value;

  // Scan pipeline
  logic [SCAN_W-1:0]   scan_idx;
  logic                rd_vld;
  logic [IDX_W-1:0]    rd_idx;
  row_t                rd_row;

  // Scan trackers
  logic                found_vld;
  logic [IDX_W-1:0]    found_idx;
  logic [VAL_W-1:0]    found_value;
  logic [CNT_W-1:0]    found_count;
  logic                victim_vld;
  logic [IDX_W-1:0]    victim_idx;
  logic [KEY_W-1:0]    victim_key;
  logic [CNT_W-1:0]    victim_count;
  logic [STAMP_W-1:0]  victim_stamp;
  logic                free_vld;
  logic [IDX_W-1:0]    free_idx;
  logic [OCC_W-1:0]    occupied;

  // Commit decisions
  logic                issue;
  logic                better;
  logic [CMP_W-1:0]    cap_ext;
  logic [CMP_W-1:0]    cap_eff;
  logic                full;
  logic                do_evict;
  logic                wr_en;
  logic [IDX_W-1:0]    wr_idx;
  row_t                wr_row;
  logic [CNT_W-1:0]    count_inc;

  assign issue         = (scan_idx != SCAN_W'(ENTRIES));
  assign sts.scan_last = rd_vld && (rd_idx == IDX_W'(ENTRIES - 1));

  // Candidate beats current victim: smaller count, then older access
  assign better = !victim_vld || (rd_row.count < victim_count) ||
                  ((rd_row.count == victim_count) && (rd_row.stamp < victim_stamp));

  // Clamp the capacity into 1..ENTRIES
  always_comb begin
    cap_ext = CMP_W'(capacity);
    if (cap_ext == '0) begin
      cap_eff = CMP_W'(1);
    end else if (cap_ext > CMP_W'(ENTRIES)) begin
      cap_eff = CMP_W'(ENTRIES);
    end else begin
      cap_eff = cap_ext;
    end
  end

  assign full      = (CMP_W'(occupied) >= cap_eff);
  assign count_inc = (found_count == COUNT_MAX) ? found_count : found_count + COUNT_ONE;

  // Pick the write-back slot and row
  always_comb begin
    do_evict     = 1'b0;
    wr_en        = 1'b0;
    wr_idx       = found_idx;
    wr_row.key   = req_key;
    wr_row.value = req_value;
    wr_row.count = COUNT_ONE;
    wr_row.stamp = access_clock;
    if (found_vld) begin
      wr_en        = 1'b1;
      wr_row.value = (req_put == REQ_PUT) ? req_value : found_value;
      wr_row.count = count_inc;
    end else if (req_put == REQ_PUT) begin
      if (full && victim_vld) begin
        do_evict = 1'b1;
        wr_en    = 1'b1;
        wr_idx   = victim_idx;
      end else begin
        wr_en  = free_vld;
        wr_idx = free_idx;
      end
    end
  end

  // Row memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.commit && wr_en) begin
      mem[wr_idx] <= wr_row;
    end
    if (cmd.scan && issue) begin
      rd_row <= mem[scan_idx[IDX_W-1:0]];
    end
  end

  // Configuration, valid bits and access clock
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity     <= CAP_RESET;
      valid        <= '0;
      access_clock <= '0;
    end else begin
      if (cfg_wr) begin
        capacity <= cfg_data;
      end
      if (cmd.commit && wr_en) begin
        valid[wr_idx] <= 1'b1;
        access_clock  <= access_clock + STAMP_W'(1);
      end
    end
  end

  // Latch the request
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_put   <= req_type;
      req_key   <= key;
      req_value <= write_value;
    end
  end

  // Scan: issue one read per cycle, compare the row read last cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_idx   <= '0;
      rd_vld     <= 1'b0;
      found_vld  <= 1'b0;
      victim_vld <= 1'b0;
      free_vld   <= 1'b0;
      occupied   <= '0;
    end else if (cmd.load) begin
      scan_idx   <= '0;
      rd_vld     <= 1'b0;
      found_vld  <= 1'b0;
      victim_vld <= 1'b0;
      free_vld   <= 1'b0;
      occupied   <= '0;
    end else if (cmd.scan) begin
      rd_vld <= issue;
      if (issue) begin
        rd_idx   <= scan_idx[IDX_W-1:0];
        scan_idx <= scan_idx + SCAN_W'(1);
      end
      if (rd_vld) begin
        if (valid[rd_idx]) begin
          occupied <= occupied + OCC_W'(1);
          if (!found_vld && (rd_row.key == req_key)) begin
            found_vld   <= 1'b1;
            found_idx   <= rd_idx;
            found_value <= rd_row.value;
            found_count <= rd_row.count;
          end
          if (better) begin
            victim_vld   <= 1'b1;
            victim_idx   <= rd_idx;
            victim_key   <= rd_row.key;
            victim_count <= rd_row.count;
            victim_stamp <= rd_row.stamp;
          end
        end else if (!free_vld) begin
          free_vld <= 1'b1;
          free_idx <= rd_idx;
        end
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      hit         <= found_vld;
      read_value  <= (found_vld && (req_put == REQ_GET)) ? found_value : '0;
      evicted     <= do_evict;
      evicted_key <= do_evict ? victim_key : '0;
    end
  end

endmodule

`default_nettype wire

// ===== sv/lfu_cache_table_top.sv =====
// LFU cache table, top level: joins the controller and the datapath.
// Depends on lfu_pkg, lfu_ctrl and lfu_datapath.
//
// Usage:
//   Request channel (in_valid/in_ready): req_type (get or put), key,
//   write_value. One result per request on the result channel
//   (out_valid/out_ready): hit, read_value, evicted, evicted_key.
//   Configuration channel (cfg_valid/cfg_ready): cache_capacity, always
//   ready; write it only while no request is in flight.
//   The result is registered after the table is scanned one slot per
//   cycle through the single read port of the row memory, plus a
//   registered read and a write-back step. The controller then returns
//   to idle, so a new request is accepted only once the previous one
//   has been written back, never while one is still being scanned.
//   The result sits in an output register; the next request is accepted
//   while it waits. If the receiver stalls, the following request holds
//   in its write-back step until the result register drains.
//   Reset clears all valid bits, the access clock and sets the capacity
//   to 16; row contents are not cleared and no sweep is needed.
`default_nettype none

module lfu_cache_table_top
  import lfu_pkg::*;
#(
  parameter int ENTRIES = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CAP_W-1:0]         cache_capacity,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic                     req_type,
  input  logic signed [KEY_W-1:0]  key,
  input  logic signed [VAL_W-1:0]  write_value,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic                     hit,
  output logic signed [VAL_W-1:0]  read_value,
  output logic                     evicted,
  output logic signed [KEY_W-1:0]  evicted_key
);

  ctl_cmd_t cmd;
  ctl_sts_t sts;

  assign cfg_ready = 1'b1;

  lfu_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  lfu_datapath #(
    .ENTRIES (ENTRIES)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .cfg_wr      (cfg_valid && cfg_ready),
    .cfg_data    (cache_capacity),
    .req_type    (req_type),
    .key         (key),
    .write_value (write_value),
    .hit         (hit),
    .read_value  (read_value),
    .evicted     (evicted),
    .evicted_key (evicted_key)
  );

endmodule

`default_nettype wire
